>>> rtl/ccir_pkg.sv
// ----------------------------------------------------------------------------
// Circle contact impulse resolver package
// Shared widths, beat layouts, pipeline records and arithmetic helpers.
// ----------------------------------------------------------------------------
package ccir_pkg;

  localparam int FracBits   = 16;
  localparam int RestiBits  = 17;
  localparam int SqrtStages = 16;
  localparam int DivSteps   = 17;
  localparam int InBits     = 288;
  localparam int OutBits    = 328;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        ra;
    logic [30:0]        rb;
    logic [30:0]        ima;
    logic [30:0]        imb;
    logic [15:0]        ba;
    logic [15:0]        bb;
    logic [31:0]        adx;
    logic [31:0]        ady;
    logic               sx;
    logic               sy;
  } side1_t;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [15:0]        ba;
    logic [15:0]        bb;
    logic               sx;
    logic               sy;
    logic signed [33:0] depth;
    logic [32:0]        dmag;
    logic               dz;
    logic               mz;
  } side2_t;

  typedef struct packed {
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic [16:0]        nxm;
    logic [16:0]        nym;
    logic               nxneg;
    logic               nyneg;
    logic               txneg;
    logic               tyneg;
    logic signed [33:0] depth;
    logic [32:0]        dmag;
    logic               mz;
    logic [16:0]        wa;
    logic [16:0]        wb;
    logic [15:0]        ba;
    logic [15:0]        bb;
  } car_t;

  typedef struct packed {
    logic        applied;
    logic [31:0] kby;
    logic [31:0] kbx;
    logic [31:0] kay;
    logic [31:0] kax;
    logic [31:0] pby;
    logic [31:0] pbx;
    logic [31:0] pay;
    logic [31:0] pax;
    logic [17:0] ny;
    logic [17:0] nx;
    logic [31:0] depth;
  } res_t;

  function automatic sq_t sqrt_step(input sq_t s, input int unsigned k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t         o;
    b = 64'd1 << (62 - 2 * k);
    t = s.r + b;
    if (s.v >= t) begin
      o.v = s.v - t;
      o.r = (s.r >> 1) + b;
    end else begin
      o.v = s.v;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  function automatic logic [31:0] sat32(input logic neg, input logic [39:0] m);
    logic [31:0] r;
    if (neg) begin
      if (m > 40'h00_8000_0000) r = 32'h8000_0000;
      else r = 32'd0 - m[31:0];
    end else begin
      if (m > 40'h00_7FFF_FFFF) r = 32'h7FFF_FFFF;
      else r = m[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/ccir_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root of a 64-bit value, two result bits per register stage.
// ----------------------------------------------------------------------------
module ccir_sqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);

  ccir_pkg::sq_t st_q [ccir_pkg::SqrtStages];

  for (genvar s = 0; s < ccir_pkg::SqrtStages; s++) begin : g_stage
    ccir_pkg::sq_t prev;
    ccir_pkg::sq_t mid;
    ccir_pkg::sq_t st_d;
    if (s == 0) begin : g_first
      assign prev = '{v: rad_i, r: 64'd0};
    end else begin : g_next
      assign prev = st_q[s-1];
    end
    always_comb begin
      mid  = ccir_pkg::sqrt_step(prev, 2 * s);
      st_d = ccir_pkg::sqrt_step(mid, 2 * s + 1);
    end
    always_ff @(posedge clk_i) begin
      if (en_i) st_q[s] <= st_d;
    end
  end

  assign root_o = st_q[ccir_pkg::SqrtStages-1].r[31:0];

endmodule

>>> rtl/ccir_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// 48-bit dividend over 32-bit divisor, 17-bit quotient, one bit per stage.
// ----------------------------------------------------------------------------
module ccir_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] num_i,
  input  logic [31:0] den_i,
  output logic [16:0] quo_o
);

  logic [47:0] rem_q [ccir_pkg::DivSteps];
  logic [31:0] den_q [ccir_pkg::DivSteps];
  logic [16:0] quo_q [ccir_pkg::DivSteps];

  for (genvar j = 0; j < ccir_pkg::DivSteps; j++) begin : g_step
    logic [47:0] rem_p;
    logic [31:0] den_p;
    logic [16:0] quo_p;
    logic [47:0] sub;
    logic [47:0] rem_d;
    logic [16:0] quo_d;
    if (j == 0) begin : g_first
      assign rem_p = num_i;
      assign den_p = den_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[j-1];
      assign den_p = den_q[j-1];
      assign quo_p = quo_q[j-1];
    end
    always_comb begin
      sub   = {16'd0, den_p} << (ccir_pkg::DivSteps - 1 - j);
      rem_d = rem_p;
      quo_d = quo_p;
      if (rem_p >= sub) begin
        rem_d = rem_p - sub;
        quo_d[ccir_pkg::DivSteps-1-j] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        den_q[j] <= den_p;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[ccir_pkg::DivSteps-1];

endmodule

>>> rtl/circle_contact_impulse_resolver_top.sv
// ----------------------------------------------------------------------------
// Circle contact impulse resolver
// Depth, normal, positional correction and restitution impulse for one
// touching circle pair per beat, Q16.16 fixed point with saturated outputs.
// ----------------------------------------------------------------------------
// Channel | Dir | Beat contents
// s_axis  | in  | rel_pos_x/y, rel_vel_x/y, radius_a/b, inv_mass_a/b, bounce_a/b
// m_axis  | out | depth, normal_x/y, push_a/b_x/y, kick_a/b_x/y, impulse_applied
//
// One beat is taken per cycle unless the input is stalled.
// The pipeline runs through the 16-stage square root and the 17-stage dividers.
// Reset clears every valid bit and the two-entry output buffer.
// The input stalls only while the output buffer holds two unaccepted beats.
// ----------------------------------------------------------------------------
module circle_contact_impulse_resolver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // rel_pos_x, rel_pos_y, rel_vel_x, rel_vel_y, radius_a, radius_b,
  // inv_mass_a, inv_mass_b, bounce_a, bounce_b, zero pad
  input  logic [ccir_pkg::InBits-1:0]   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // depth, normal_x, normal_y, push_a_x, push_a_y, push_b_x, push_b_y,
  // kick_a_x, kick_a_y, kick_b_x, kick_b_y, impulse_applied, zero pad
  output logic [ccir_pkg::OutBits-1:0]  m_tdata_o
);

  logic en;

  // Stage A: input capture.
  logic               a_v_q;
  logic signed [31:0] a_px_q, a_py_q;
  ccir_pkg::side1_t   a_s_q;

  // Stage B: squares.
  logic               b_v_q;
  ccir_pkg::side1_t   b_s_q, b_s_d;
  logic [63:0]        b_sqx_q, b_sqy_q;

  // Stage C: sum of squares.
  logic               c_v_q;
  ccir_pkg::side1_t   c_s_q;
  logic [63:0]        c_sum_q;

  logic               v1_q  [ccir_pkg::SqrtStages];
  ccir_pkg::side1_t   sd1_q [ccir_pkg::SqrtStages];
  logic [31:0]        root;

  // Stage D: depth and divider operands.
  logic               d_v_q;
  ccir_pkg::side2_t   d_s_q, d_s_d;
  logic [47:0]        d_numx_q, d_numy_q, d_numa_q, d_numb_q;
  logic [31:0]        d_dist_q, d_msum_q;
  ccir_pkg::side1_t   s1l;
  logic [31:0]        msum_d;

  logic               v2_q  [ccir_pkg::DivSteps];
  ccir_pkg::side2_t   sd2_q [ccir_pkg::DivSteps];
  logic [16:0]        qx, qy, qa, qb;

  logic               pv_q  [7];
  ccir_pkg::car_t     car_q [6];
  ccir_pkg::car_t     car_d;
  ccir_pkg::side2_t   s2l;

  logic [49:0]        f_txp_q, f_typ_q;
  logic signed [49:0] f_vxn_q, f_vyn_q;

  logic [50:0]        g_pax_q, g_pay_q, g_pbx_q, g_pby_q;
  logic signed [50:0] g_vn2_q;
  logic [17:0]        g_f_q;

  logic               h_le_q;
  logic [32:0]        h_vnm_q;
  logic [17:0]        h_f_q;
  logic [31:0]        h_pax_q, h_pay_q, h_pbx_q, h_pby_q;
  logic [50:0]        vabs;

  logic               i_le_q;
  logic [50:0]        i_gp_q;
  logic [31:0]        i_pax_q, i_pay_q, i_pbx_q, i_pby_q;

  logic               j_le_q;
  logic [50:0]        j_hap_q, j_hbp_q;
  logic [31:0]        j_pax_q, j_pay_q, j_pbx_q, j_pby_q;

  logic               k_le_q;
  logic [50:0]        k_kax_q, k_kay_q, k_kbx_q, k_kby_q;
  logic [31:0]        k_pax_q, k_pay_q, k_pbx_q, k_pby_q;

  ccir_pkg::res_t     l_q, l_d;

  ccir_pkg::res_t     fifo_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  assign en         = (cnt_q != 2'd2);
  assign s_tready_o = en;

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
      for (int i = 0; i < ccir_pkg::SqrtStages; i++) v1_q[i] <= 1'b0;
      for (int i = 0; i < ccir_pkg::DivSteps; i++) v2_q[i] <= 1'b0;
      for (int i = 0; i < 7; i++) pv_q[i] <= 1'b0;
    end else if (en) begin
      a_v_q   <= s_tvalid_i;
      b_v_q   <= a_v_q;
      c_v_q   <= b_v_q;
      v1_q[0] <= c_v_q;
      for (int i = 1; i < ccir_pkg::SqrtStages; i++) v1_q[i] <= v1_q[i-1];
      d_v_q   <= v1_q[ccir_pkg::SqrtStages-1];
      v2_q[0] <= d_v_q;
      for (int i = 1; i < ccir_pkg::DivSteps; i++) v2_q[i] <= v2_q[i-1];
      pv_q[0] <= v2_q[ccir_pkg::DivSteps-1];
      for (int i = 1; i < 7; i++) pv_q[i] <= pv_q[i-1];
    end
  end

  always_comb begin
    b_s_d     = a_s_q;
    b_s_d.adx = a_px_q[31] ? 32'd0 - a_px_q : a_px_q;
    b_s_d.ady = a_py_q[31] ? 32'd0 - a_py_q : a_py_q;
  end

  assign s1l = sd1_q[ccir_pkg::SqrtStages-1];

  always_comb begin
    d_s_d.vx    = s1l.vx;
    d_s_d.vy    = s1l.vy;
    d_s_d.ba    = s1l.ba;
    d_s_d.bb    = s1l.bb;
    d_s_d.sx    = s1l.sx;
    d_s_d.sy    = s1l.sy;
    d_s_d.depth = $signed({3'b0, s1l.ra} + {3'b0, s1l.rb} - {2'b0, root});
    d_s_d.dmag  = d_s_d.depth[33] ? 33'(34'd0 - d_s_d.depth) : d_s_d.depth[32:0];
    d_s_d.dz    = (root == 32'd0);
    msum_d      = {1'b0, s1l.ima} + {1'b0, s1l.imb};
    d_s_d.mz    = (msum_d == 32'd0);
  end

  assign s2l = sd2_q[ccir_pkg::DivSteps-1];

  always_comb begin
    car_d.nxm   = s2l.dz ? 17'h10000 : qx;
    car_d.nym   = s2l.dz ? 17'd0 : qy;
    car_d.nxneg = !s2l.dz && s2l.sx;
    car_d.nyneg = !s2l.dz && s2l.sy;
    car_d.nx    = car_d.nxneg ? $signed(18'd0 - {1'b0, car_d.nxm}) : $signed({1'b0, car_d.nxm});
    car_d.ny    = car_d.nyneg ? $signed(18'd0 - {1'b0, car_d.nym}) : $signed({1'b0, car_d.nym});
    car_d.txneg = car_d.nxneg ^ s2l.depth[33];
    car_d.tyneg = car_d.nyneg ^ s2l.depth[33];
    car_d.depth = s2l.depth;
    car_d.dmag  = s2l.dmag;
    car_d.mz    = s2l.mz;
    car_d.wa    = qa;
    car_d.wb    = qb;
    car_d.ba    = s2l.ba;
    car_d.bb    = s2l.bb;
  end

  assign vabs = g_vn2_q[50] ? 51'd0 - g_vn2_q : g_vn2_q;

  always_comb begin
    l_d.depth   = ccir_pkg::sat32(car_q[5].depth[33], {7'd0, car_q[5].dmag});
    l_d.nx      = car_q[5].nx;
    l_d.ny      = car_q[5].ny;
    l_d.applied = !car_q[5].mz && k_le_q;
    l_d.pax     = car_q[5].mz ? 32'd0 : k_pax_q;
    l_d.pay     = car_q[5].mz ? 32'd0 : k_pay_q;
    l_d.pbx     = car_q[5].mz ? 32'd0 : k_pbx_q;
    l_d.pby     = car_q[5].mz ? 32'd0 : k_pby_q;
    l_d.kax     = ccir_pkg::sat32(car_q[5].nxneg, {5'd0, k_kax_q[50:16]});
    l_d.kay     = ccir_pkg::sat32(car_q[5].nyneg, {5'd0, k_kay_q[50:16]});
    l_d.kbx     = ccir_pkg::sat32(!car_q[5].nxneg, {5'd0, k_kbx_q[50:16]});
    l_d.kby     = ccir_pkg::sat32(!car_q[5].nyneg, {5'd0, k_kby_q[50:16]});
    if (!l_d.applied) begin
      l_d.kax = 32'd0;
      l_d.kay = 32'd0;
      l_d.kbx = 32'd0;
      l_d.kby = 32'd0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_px_q     <= s_tdata_i[31:0];
      a_py_q     <= s_tdata_i[63:32];
      a_s_q.vx   <= s_tdata_i[95:64];
      a_s_q.vy   <= s_tdata_i[127:96];
      a_s_q.ra   <= s_tdata_i[158:128];
      a_s_q.rb   <= s_tdata_i[189:159];
      a_s_q.ima  <= s_tdata_i[220:190];
      a_s_q.imb  <= s_tdata_i[251:221];
      a_s_q.ba   <= s_tdata_i[267:252];
      a_s_q.bb   <= s_tdata_i[283:268];
      a_s_q.adx  <= 32'd0;
      a_s_q.ady  <= 32'd0;
      a_s_q.sx   <= s_tdata_i[31];
      a_s_q.sy   <= s_tdata_i[63];

      b_s_q      <= b_s_d;
      b_sqx_q    <= b_s_d.adx * b_s_d.adx;
      b_sqy_q    <= b_s_d.ady * b_s_d.ady;

      c_s_q      <= b_s_q;
      c_sum_q    <= b_sqx_q + b_sqy_q;

      sd1_q[0]   <= c_s_q;
      for (int i = 1; i < ccir_pkg::SqrtStages; i++) sd1_q[i] <= sd1_q[i-1];

      d_s_q      <= d_s_d;
      d_numx_q   <= {s1l.adx, 16'd0};
      d_numy_q   <= {s1l.ady, 16'd0};
      d_numa_q   <= {1'b0, s1l.ima, 16'd0};
      d_numb_q   <= {1'b0, s1l.imb, 16'd0};
      d_dist_q   <= root;
      d_msum_q   <= msum_d;

      sd2_q[0]   <= d_s_q;
      for (int i = 1; i < ccir_pkg::DivSteps; i++) sd2_q[i] <= sd2_q[i-1];

      car_q[0]   <= car_d;
      for (int i = 1; i < 6; i++) car_q[i] <= car_q[i-1];
      f_txp_q    <= car_d.nxm * car_d.dmag;
      f_typ_q    <= car_d.nym * car_d.dmag;
      f_vxn_q    <= s2l.vx * car_d.nx;
      f_vyn_q    <= s2l.vy * car_d.ny;

      g_pax_q    <= f_txp_q[49:16] * car_q[0].wa;
      g_pay_q    <= f_typ_q[49:16] * car_q[0].wa;
      g_pbx_q    <= f_txp_q[49:16] * car_q[0].wb;
      g_pby_q    <= f_typ_q[49:16] * car_q[0].wb;
      g_vn2_q    <= 51'(f_vxn_q) + 51'(f_vyn_q);
      g_f_q      <= 18'h20000 + {2'b0, car_q[0].ba} + {2'b0, car_q[0].bb};

      h_le_q     <= g_vn2_q[50] || (g_vn2_q == 51'sd0);
      h_vnm_q    <= vabs[48:16];
      h_f_q      <= g_f_q;
      h_pax_q    <= ccir_pkg::sat32(car_q[1].txneg, {5'd0, g_pax_q[50:16]});
      h_pay_q    <= ccir_pkg::sat32(car_q[1].tyneg, {5'd0, g_pay_q[50:16]});
      h_pbx_q    <= ccir_pkg::sat32(!car_q[1].txneg, {5'd0, g_pbx_q[50:16]});
      h_pby_q    <= ccir_pkg::sat32(!car_q[1].tyneg, {5'd0, g_pby_q[50:16]});

      i_le_q     <= h_le_q;
      i_gp_q     <= h_vnm_q * h_f_q;
      i_pax_q    <= h_pax_q;
      i_pay_q    <= h_pay_q;
      i_pbx_q    <= h_pbx_q;
      i_pby_q    <= h_pby_q;

      j_le_q     <= i_le_q;
      j_hap_q    <= i_gp_q[50:17] * car_q[3].wa;
      j_hbp_q    <= i_gp_q[50:17] * car_q[3].wb;
      j_pax_q    <= i_pax_q;
      j_pay_q    <= i_pay_q;
      j_pbx_q    <= i_pbx_q;
      j_pby_q    <= i_pby_q;

      k_le_q     <= j_le_q;
      k_kax_q    <= j_hap_q[49:16] * car_q[4].nxm;
      k_kay_q    <= j_hap_q[49:16] * car_q[4].nym;
      k_kbx_q    <= j_hbp_q[49:16] * car_q[4].nxm;
      k_kby_q    <= j_hbp_q[49:16] * car_q[4].nym;
      k_pax_q    <= j_pax_q;
      k_pay_q    <= j_pay_q;
      k_pbx_q    <= j_pbx_q;
      k_pby_q    <= j_pby_q;

      l_q        <= l_d;
    end
  end

  ccir_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (c_sum_q),
    .root_o (root)
  );

  ccir_div u_div_nx (.clk_i(clk_i), .en_i(en), .num_i(d_numx_q), .den_i(d_dist_q), .quo_o(qx));
  ccir_div u_div_ny (.clk_i(clk_i), .en_i(en), .num_i(d_numy_q), .den_i(d_dist_q), .quo_o(qy));
  ccir_div u_div_wa (.clk_i(clk_i), .en_i(en), .num_i(d_numa_q), .den_i(d_msum_q), .quo_o(qa));
  ccir_div u_div_wb (.clk_i(clk_i), .en_i(en), .num_i(d_numb_q), .den_i(d_msum_q), .quo_o(qb));

  // Output buffer.
  assign push = pv_q[6] && en;
  assign pop  = (cnt_q != 2'd0) && m_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wp_q] <= l_q;
  end

  assign m_tvalid_o = (cnt_q != 2'd0);
  assign m_tdata_o  = {3'b0, fifo_q[rp_q]};

endmodule

>>> rtl/ccir_checker.sv
// ----------------------------------------------------------------------------
// Circle contact impulse resolver port checker
// Concurrent checks on the stream ports of the top level.
// ----------------------------------------------------------------------------
module ccir_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tvalid_i,
  input logic                          s_tready_o,
  input logic [ccir_pkg::InBits-1:0]   s_tdata_i,
  input logic                          m_tvalid_o,
  input logic                          m_tready_i,
  input logic [ccir_pkg::OutBits-1:0]  m_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("stalled output beat changed");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready_o |-> m_tvalid_o)
    else $error("input stalled with no result waiting");

  a_normal_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> ($signed(m_tdata_o[49:32]) <= 18'sd65536)
               && ($signed(m_tdata_o[49:32]) >= -18'sd65536)
               && ($signed(m_tdata_o[67:50]) <= 18'sd65536)
               && ($signed(m_tdata_o[67:50]) >= -18'sd65536))
    else $error("normal component out of unit range");

  a_no_kick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tdata_o[324] |-> (m_tdata_o[323:196] == 128'd0))
    else $error("velocity change without impulse");

endmodule

bind circle_contact_impulse_resolver_top ccir_checker u_ccir_checker (.*);
